@@ hw/rtl/ssr_pkg.sv @@
`default_nettype none
// ============================================================================
// ssr_pkg: shared types and constants for the subset-sum reachability block
// Holds the bitmap geometry, the payload structs of both channels and the
// command bundle that the controller sends to the datapath.
// ============================================================================
package ssr_pkg;

    // Bitmap geometry: one bit per sum from zero to SUM_LIMIT.
    localparam int SUM_LIMIT = 8191;
    localparam int WORD_BITS = 64;
    localparam int NWORDS    = SUM_LIMIT / WORD_BITS + 1;
    localparam int ADDR_W    = $clog2(NWORDS);
    localparam int BIT_W     = $clog2(WORD_BITS);
    localparam int VAL_W     = 13;
    // Step counter holds 0 .. NWORDS, one step per source word plus one.
    localparam int CNT_W     = ADDR_W + 1;
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    // Register indexes of the configuration port.
    localparam logic REG_TARGET_SUM = 1'b0;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef struct packed {
        logic             first_item;
        logic [VAL_W-1:0] element_value;
    } in_item_t;

    typedef struct packed {
        logic target_reachable;
        logic sums_truncated;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             start;
        logic             step;
        logic [CNT_W-1:0] cnt;
        logic             lookup;
        logic             capture;
    } ssr_cmd_t;

    // Value that a bitmap word holds after a clear: only the empty sum.
    function automatic word_t reset_word(input logic [ADDR_W-1:0] addr);
        word_t w;
        w = '0;
        if (addr == '0)
        begin
            w[0] = 1'b1;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/ssr_ctrl.sv @@
`default_nettype none
// ============================================================================
// ssr_ctrl: sequencer of the subset-sum reachability block
// Accepts an element, steps the datapath through one pass over the bitmap,
// looks up the target word and hands the result to the output register.
// ============================================================================
module ssr_ctrl
    import ssr_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    output ssr_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_FLUSH = 5'b00100,
        S_LOOK  = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(NWORDS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             start;
    logic             capture;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign start     = in_valid && in_ready;
    assign capture   = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Commands to the datapath.
    always_comb
    begin
        cmd.start   = start;
        cmd.step    = (state_reg == S_SCAN);
        cmd.cnt     = cnt_reg;
        cmd.lookup  = (state_reg == S_LOOK);
        cmd.capture = capture;
    end

    // Next state and step counter.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (cnt_reg == STEP_LAST)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_FLUSH: state_next = S_LOOK;
            S_LOOK:  state_next = S_DONE;
            S_DONE:
            begin
                if (capture)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The output slot fills on capture and empties on a transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (capture)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/ssr_dp.sv @@
`default_nettype none
// ============================================================================
// ssr_dp: bitmap memory and shift-or datapath
// Streams source words from the top down, shifts them by the element value
// and ORs them into the destination words in place. Words above the bitmap
// feed the truncation flag. Per-word valid bits clear the whole bitmap at once.
// ============================================================================
module ssr_dp
    import ssr_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ssr_cmd_t         cmd,
    input  wire in_item_t         in_data,
    input  wire logic [VAL_W-1:0] target_sum,
    output out_item_t             out_data
);

    localparam int W_W = CNT_W + 1;

    // Bitmap memory and per-word valid bits.
    word_t             mem [NWORDS];
    logic [NWORDS-1:0] valid_reg;

    logic [VAL_W-1:0]  value_reg;
    logic              trunc_reg;
    word_t             prev_reg;
    out_item_t         out_data_reg;

    // Read stage registers.
    word_t             rd_a_reg, rd_b_reg;
    logic              va_reg, vb_reg;
    logic              s1_step_reg, s1_jneg_reg, s1_win_reg;
    logic [ADDR_W-1:0] s1_jaddr_reg, s1_waddr_reg;

    logic [ADDR_W-1:0] a_addr, b_addr;
    logic [W_W-1:0]    w_full;
    logic              j_neg, w_in;
    logic [ADDR_W-1:0] q;
    logic [BIT_W-1:0]  r;
    word_t             src_word, dst_word, shifted, new_word;
    logic              we;

    assign q = value_reg[VAL_W-1:BIT_W];
    assign r = value_reg[BIT_W-1:0];

    // Step cnt reads source word NWORDS-1-cnt and destination word
    // NWORDS-cnt+q; the last step has no source word inside the bitmap.
    always_comb
    begin
        j_neg  = cmd.cnt[ADDR_W];
        a_addr = ADDR_W'(CNT_W'(NWORDS - 1) - cmd.cnt);
        w_full = W_W'(NWORDS) + W_W'(q) - W_W'(cmd.cnt);
        w_in   = (w_full[W_W-1:ADDR_W] == '0);
        b_addr = cmd.lookup ? target_sum[VAL_W-1:BIT_W] : w_full[ADDR_W-1:0];
    end

    // Memory: two registered reads and one write per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            rd_a_reg <= mem[a_addr];
            va_reg   <= valid_reg[a_addr];
        end
        if (cmd.step || cmd.lookup)
        begin
            rd_b_reg     <= mem[b_addr];
            vb_reg       <= valid_reg[b_addr];
            s1_jaddr_reg <= a_addr;
            s1_waddr_reg <= b_addr;
        end
        if (we)
        begin
            mem[s1_waddr_reg] <= new_word;
        end
    end

    // Combine stage: a word that was never written since the last clear
    // reads as its cleared value.
    always_comb
    begin
        src_word = s1_jneg_reg ? '0 : (va_reg ? rd_a_reg : reset_word(s1_jaddr_reg));
        dst_word = vb_reg ? rd_b_reg : reset_word(s1_waddr_reg);
        if (r == '0)
        begin
            shifted = prev_reg;
        end
        else
        begin
            shifted = (prev_reg << r) | (src_word >> (BIT_W'(0) - r));
        end
        new_word = dst_word | shifted;
        we       = s1_step_reg && s1_win_reg;
    end

    // Control registers of the pipeline, valid bits and the sticky flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            trunc_reg   <= 1'b0;
            s1_step_reg <= 1'b0;
            s1_jneg_reg <= 1'b0;
            s1_win_reg  <= 1'b0;
        end
        else
        begin
            s1_step_reg <= cmd.step;
            if (cmd.step)
            begin
                s1_jneg_reg <= j_neg;
                s1_win_reg  <= w_in;
            end
            if (cmd.start && in_data.first_item)
            begin
                valid_reg <= '0;
                trunc_reg <= 1'b0;
            end
            else
            begin
                if (we)
                begin
                    valid_reg[s1_waddr_reg] <= 1'b1;
                end
                // Sums shifted past the top word are dropped.
                if (s1_step_reg && !s1_win_reg && (shifted != '0))
                begin
                    trunc_reg <= 1'b1;
                end
            end
        end
    end

    // Element latch, source word history and result register.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg <= in_data.element_value;
            prev_reg  <= '0;
        end
        else if (s1_step_reg)
        begin
            prev_reg <= src_word;
        end
        if (cmd.capture)
        begin
            out_data_reg.target_reachable <= dst_word[target_sum[BIT_W-1:0]];
            out_data_reg.sums_truncated   <= trunc_reg;
        end
    end

    assign out_data = out_data_reg;

endmodule
`default_nettype wire

@@ hw/rtl/subset_sum_reachability.sv @@
`default_nettype none
// ============================================================================
// subset_sum_reachability: subset-sum reachability bitmap engine
// Tracks which sums up to 8191 can be formed from the elements of the current
// set and reports whether the configured target sum is reachable.
// ============================================================================
// Usage:
//   Input channel (in_valid/in_ready/in_data): one set element per transfer.
//   first_item starts a new set: the bitmap drops back to only the empty sum
//   and the truncation flag clears before the element is added.
//   Output channel (out_valid/out_ready/out_data): one result per element,
//   holding target reachability and the sticky truncation flag.
//   Each element takes one pass over the 128 bitmap words, one word per
//   cycle through the dual-read memory, then the pipeline flush and the
//   target lookup, before its result is captured into the output register.
//   The next element is taken while a finished result still waits in the
//   output register; a stalled receiver holds the block only once the next
//   result is ready and the previous one is still not taken.
//   Reset empties the output slot, sets the bitmap to only the empty sum and
//   clears the flag and target_sum.
//   target_sum lies at APB address 0; write it only while idle (not enforced).
// ============================================================================
module subset_sum_reachability
    import ssr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire in_item_t           in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output out_item_t               out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready
);

    ssr_cmd_t         cmd;
    logic [VAL_W-1:0] target_reg;
    logic             sel_target;

    // Configuration register file.
    assign pready     = 1'b1;
    assign sel_target = (paddr[PADDR_W-1:2] == REG_TARGET_SUM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && sel_target)
        begin
            target_reg <= pwdata[VAL_W-1:0];
        end
    end

    assign prdata = sel_target ? DATA_W'(target_reg) : '0;

    ssr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ssr_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_data    (in_data),
        .target_sum (target_reg),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire

@@ tb/sv/subset_sum_reachability_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// subset_sum_reachability_tb: self-checking bench for the reachability engine
// Streams set elements into the block with random gaps on both channels. A
// bit-level copy of the sum bitmap predicts each result and checks it.
// Covers target_sum writes, readback and an unmapped APB address.
// ============================================================================
module subset_sum_reachability_tb;
    import ssr_pkg::*;

    // Register addresses on the APB port.
    localparam logic [PADDR_W-1:0] ADDR_TARGET   = {REG_TARGET_SUM, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = {~REG_TARGET_SUM, 2'b00};

    localparam int RANDOM_PHASE_ITEMS = 125;
    localparam int LONG_HOLD          = 1000;
    localparam int HOLD_AT_FIRST      = 60;
    localparam int HOLD_AT_SECOND     = 400;
    localparam int DRAIN_CYCLES       = 300;
    localparam int WATCHDOG_LIMIT     = 6000;

    logic                clk;
    logic                rst_n    = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    in_item_t            in_data  = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    out_item_t           out_data;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [DATA_W-1:0]   pwdata  = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // Predicted state of the block.
    bit [SUM_LIMIT:0]    sums_reachable = {{SUM_LIMIT{1'b0}}, 1'b1};
    bit                  sums_dropped   = 1'b0;
    logic [VAL_W-1:0]    target_model   = '0;

    in_item_t            element_queue[$];
    out_item_t           pending_results[$];

    int                  tx_gap_max   = 4;
    int                  rx_gap_max   = 4;
    int                  tx_wait      = 0;
    int                  rx_wait      = 0;
    int                  rx_hold      = 0;
    int                  results_seen = 0;
    int                  idle_cycles  = 0;
    int                  error_count  = 0;

    subset_sum_reachability dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    // Adds one element to the predicted bitmap and queues the expected result.
    function automatic void add_element_to_sums(input in_item_t item);
        bit [2*SUM_LIMIT+1:0] shifted;
        out_item_t            expected;
        if (item.first_item)
        begin
            // A new set starts from the empty sum alone.
            sums_reachable    = '0;
            sums_reachable[0] = 1'b1;
            sums_dropped      = 1'b0;
        end
        shifted = {{(SUM_LIMIT+1){1'b0}}, sums_reachable} << item.element_value;
        if (item.element_value != '0)
        begin
            // Bits shifted past the top are sums that no longer fit.
            if (shifted[2*SUM_LIMIT+1:SUM_LIMIT+1] != '0)
            begin
                sums_dropped = 1'b1;
            end
            sums_reachable |= shifted[SUM_LIMIT:0];
        end
        sums_reachable[0] = 1'b1;
        expected.target_reachable = sums_reachable[target_model];
        expected.sums_truncated   = sums_dropped;
        pending_results.insert(pending_results.size(), expected);
    endfunction

    // Compares one received result with the oldest expected one.
    task automatic check_result(input out_item_t got);
        out_item_t expected;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %b with no element pending", got));
        end
        else
        begin
            expected = pending_results.pop_front();
            if (got.target_reachable !== expected.target_reachable)
            begin
                report_mismatch($sformatf("result %0d target_reachable: expected %b, got %b",
                    results_seen, expected.target_reachable, got.target_reachable));
            end
            if (got.sums_truncated !== expected.sums_truncated)
            begin
                report_mismatch($sformatf("result %0d sums_truncated: expected %b, got %b",
                    results_seen, expected.sums_truncated, got.sums_truncated));
            end
        end
    endtask

    // Element driver: presents queued elements, predicting each on transfer.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            tx_wait = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                add_element_to_sums(in_data);
                tx_wait = $urandom_range(0, tx_gap_max);
            end
            if (!in_valid || in_ready)
            begin
                if (tx_wait > 0)
                begin
                    tx_wait = tx_wait - 1;
                    in_valid <= 1'b0;
                end
                else if (element_queue.size() > 0)
                begin
                    in_data  <= element_queue.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: checks each transfer and throttles out_ready, with two
    // long holds that back the block up into its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait = 0;
            rx_hold = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                check_result(out_data);
                results_seen++;
                rx_wait = $urandom_range(0, rx_gap_max);
                if (results_seen == HOLD_AT_FIRST || results_seen == HOLD_AT_SECOND)
                begin
                    rx_hold = LONG_HOLD;
                end
            end
            else if (rx_hold > 0)
            begin
                rx_hold = rx_hold - 1;
            end
            else if (rx_wait > 0)
            begin
                rx_wait = rx_wait - 1;
            end
            out_ready <= (rx_hold == 0 && rx_wait == 0);
        end
    end

    // Watchdog: ends the run when neither channel moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d idle cycles", idle_cycles);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // One APB access: setup cycle, then access cycle until pready.
    task automatic apb_access(input logic write_en, input logic [PADDR_W-1:0] addr,
                              input logic [DATA_W-1:0] wdata,
                              output logic [DATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= write_en;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (write_en && addr[PADDR_W-1:2] == REG_TARGET_SUM)
        begin
            target_model = wdata[VAL_W-1:0];
        end
    endtask

    // Writes target_sum with random upper bits, then reads it back.
    task automatic set_target(input logic [VAL_W-1:0] target);
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] rdata;
        wdata = $urandom;
        wdata[VAL_W-1:0] = target;
        apb_access(1'b1, ADDR_TARGET, wdata, rdata);
        apb_access(1'b0, ADDR_TARGET, '0, rdata);
        if (rdata !== DATA_W'(target_model))
        begin
            report_mismatch($sformatf("target_sum readback: expected %0d, got %0h",
                target_model, rdata));
        end
    endtask

    task automatic wait_until_idle();
        @(negedge clk);
        while (element_queue.size() != 0 || in_valid || pending_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic push_element(input logic first, input logic [VAL_W-1:0] value);
        in_item_t item;
        item.first_item    = first;
        item.element_value = value;
        element_queue.insert(element_queue.size(), item);
    endtask

    // Mostly small values so that sums collide, with extremes mixed in.
    function automatic logic [VAL_W-1:0] draw_element();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return VAL_W'(SUM_LIMIT);
            2, 3, 4: return VAL_W'($urandom_range(1, 63));
            5, 6:    return VAL_W'($urandom_range(0, 1023));
            7:       return VAL_W'(1) << $urandom_range(0, VAL_W - 1);
            default: return VAL_W'($urandom_range(0, SUM_LIMIT));
        endcase
    endfunction

    // One random phase: new target and idling, then sets of random elements.
    task automatic run_phase(input logic [VAL_W-1:0] target, input int tx_max,
                             input int rx_max);
        int   count;
        int   set_len;
        logic first;
        wait_until_idle();
        tx_gap_max = tx_max;
        rx_gap_max = rx_max;
        set_target(target);
        @(negedge clk);
        count = 0;
        while (count < RANDOM_PHASE_ITEMS)
        begin
            set_len = $urandom_range(1, 10);
            for (int k = 0; k < set_len; k++)
            begin
                // Now and then a set runs on from the last one or restarts midway.
                first = (k == 0) ? ($urandom_range(0, 7) != 0) : 1'b0;
                if ($urandom_range(0, 15) == 0)
                begin
                    first = 1'($urandom_range(0, 1));
                end
                push_element(first, draw_element());
                count++;
            end
        end
    endtask

    // Stimulus: reset, directed cases, then random phases.
    initial
    begin
        logic [DATA_W-1:0] rdata;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state with target zero: a zero element, the largest element,
        // then a sum that runs past the limit.
        @(negedge clk);
        push_element(1'b0, '0);
        push_element(1'b0, VAL_W'(SUM_LIMIT));
        push_element(1'b0, VAL_W'(1));
        wait_until_idle();

        // Largest target; a write to an unmapped address must not change it.
        set_target(VAL_W'(SUM_LIMIT));
        apb_access(1'b1, ADDR_UNMAPPED, 32'h0000_0123, rdata);
        apb_access(1'b0, ADDR_TARGET, '0, rdata);
        if (rdata !== DATA_W'(target_model))
        begin
            report_mismatch($sformatf("target_sum after unmapped write: got %0h", rdata));
        end

        @(negedge clk);
        push_element(1'b1, VAL_W'(SUM_LIMIT));
        push_element(1'b0, '0);
        push_element(1'b1, '0);
        push_element(1'b1, VAL_W'(4096));
        push_element(1'b0, VAL_W'(4095));
        push_element(1'b0, VAL_W'(4096));
        // Powers of two fill every sum up to the limit exactly.
        for (int k = 0; k < VAL_W; k++)
        begin
            push_element(k == 0, VAL_W'(1) << k);
        end
        push_element(1'b0, VAL_W'(1));

        run_phase(VAL_W'($urandom_range(0, 200)), 4, 4);
        run_phase(VAL_W'($urandom_range(0, SUM_LIMIT)), 0, 0);
        run_phase(VAL_W'(SUM_LIMIT), 4, 0);
        run_phase('0, 0, 4);
        run_phase(VAL_W'($urandom_range(0, 2000)), 4, 4);

        wait_until_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (error_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
